[src/utf8sr_pkg.sv]
// shared types and constants for the utf-8 script run segmenter
package utf8sr_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int NBYTES_W = 3;
    localparam int REM_W    = 2;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 2;

    localparam logic [CP_W-1:0] DEVA_LO = 21'h000900;
    localparam logic [CP_W-1:0] DEVA_HI = 21'h00097F;
    localparam logic [CP_W-1:0] CP_ZWJ  = 21'h00200D;
    localparam logic [CP_W-1:0] CP_ZWNJ = 21'h00200C;

    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] PFX_LEAD2  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] PFX_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] PFX_LEAD4  = 8'hF0;

    localparam logic [REM_W-1:0]    REM_NONE = 2'd0;
    localparam logic [REM_W-1:0]    REM_ONE  = 2'd1;
    localparam logic [REM_W-1:0]    REM_TWO  = 2'd2;
    localparam logic [REM_W-1:0]    REM_THREE = 2'd3;
    localparam logic [NBYTES_W-1:0] LEN_ONE  = 3'd1;
    localparam logic [NBYTES_W-1:0] LEN_TWO  = 3'd2;
    localparam logic [NBYTES_W-1:0] LEN_THREE = 3'd3;
    localparam logic [NBYTES_W-1:0] LEN_FOUR = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              end_of_string;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0]     code_point;
        logic [NBYTES_W-1:0] char_bytes;
        logic                is_target_script;
        logic                begins_run;
        logic                string_done;
    } result_t;

    function automatic logic is_target(input logic [CP_W-1:0] cp);
        return ((cp >= DEVA_LO) && (cp <= DEVA_HI)) || (cp == CP_ZWJ) || (cp == CP_ZWNJ);
    endfunction

endpackage

[src/utf8sr_in_stage.sv]
// input register stage for incoming byte transactions
module utf8sr_in_stage
    import utf8sr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     advance,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg, valid_next;
    in_item_t item_reg, item_next;

    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                item_next = s_item;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/utf8sr_decoder.sv]
// utf-8 decode state, character classing and run start detection
module utf8sr_decoder
    import utf8sr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     item_valid,
    input  in_item_t item,
    input  logic     advance,
    output logic     res_valid,
    output result_t  res
);

    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [NBYTES_W-1:0] len_reg, len_next;
    logic [CP_W-1:0]     pcp_reg, pcp_next;
    logic                class_reg, class_next;
    logic                start_reg, start_next;

    logic                fin;
    logic [CP_W-1:0]     cp;
    logic [NBYTES_W-1:0] nb;
    logic [CP_W-1:0]     cont_bits;
    logic [BYTE_W-1:0]   b;
    logic                last;
    logic                cls;
    logic                step;

    assign b    = item.byte_value;
    assign last = item.end_of_string;
    assign step = item_valid && advance;

    always_comb begin
        case (rem_reg)
            REM_ONE:   cont_bits = {15'd0, b[5:0]};
            REM_TWO:   cont_bits = {9'd0, b[5:0], 6'd0};
            REM_THREE: cont_bits = {3'd0, b[5:0], 12'd0};
            default:   cont_bits = '0;
        endcase
    end

    always_comb begin
        rem_next   = rem_reg;
        len_next   = len_reg;
        pcp_next   = pcp_reg;
        class_next = class_reg;
        start_next = start_reg;
        fin        = 1'b0;
        cp         = '0;
        nb         = '0;
        cls        = 1'b0;

        if (rem_reg == REM_NONE) begin
            if (!b[7]) begin
                cp  = {13'd0, b};
                nb  = LEN_ONE;
                fin = 1'b1;
            end else if ((b & MASK_LEAD2) == PFX_LEAD2) begin
                pcp_next = {10'd0, b[4:0], 6'd0};
                rem_next = REM_ONE;
                len_next = LEN_TWO;
            end else if ((b & MASK_LEAD3) == PFX_LEAD3) begin
                pcp_next = {5'd0, b[3:0], 12'd0};
                rem_next = REM_TWO;
                len_next = LEN_THREE;
            end else if ((b & MASK_LEAD4) == PFX_LEAD4) begin
                pcp_next = {b[2:0], 18'd0};
                rem_next = REM_THREE;
                len_next = LEN_FOUR;
            end else begin
                cp  = '0;
                nb  = LEN_ONE;
                fin = 1'b1;
            end
        end else begin
            pcp_next = pcp_reg | cont_bits;
            rem_next = rem_reg - REM_ONE;
            if (rem_next == REM_NONE) begin
                cp  = pcp_next;
                nb  = len_reg;
                fin = 1'b1;
            end
        end

        // cut-off character at end of string: missing bits stay zero
        if (!fin && last) begin
            cp  = pcp_next;
            nb  = len_next - {1'b0, rem_next};
            fin = 1'b1;
        end

        cls = is_target(cp);
        if (fin) begin
            rem_next   = REM_NONE;
            len_next   = '0;
            pcp_next   = '0;
            class_next = cls;
            start_next = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= REM_NONE;
            len_reg   <= '0;
            pcp_reg   <= '0;
            class_reg <= 1'b0;
            start_reg <= 1'b1;
        end else if (step) begin
            rem_reg   <= rem_next;
            len_reg   <= len_next;
            pcp_reg   <= pcp_next;
            class_reg <= class_next;
            start_reg <= start_next;
        end
    end

    assign res_valid            = item_valid && fin;
    assign res.code_point       = cp;
    assign res.char_bytes       = nb;
    assign res.is_target_script = cls;
    assign res.begins_run       = start_reg || (cls != class_reg);
    assign res.string_done      = last;

endmodule

[src/utf8sr_out_stage.sv]
// result register stage for outgoing character transactions
module utf8sr_out_stage
    import utf8sr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    res_valid,
    input  result_t res,
    output logic    advance,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign advance = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (advance) begin
            valid_next = res_valid;
            if (res_valid) begin
                res_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

[src/utf8_script_run_segmenter.sv]
// top level of the utf-8 decoder with script run segmentation
// path: a character's final byte is held in the input register, decoded combinationally and
// registered on m_ in the result register, which holds it until its transaction completes
// throughput: one byte transaction per cycle while m_tready does not stall the result register,
// as the decode between the input register and the result register is combinational
// reset: synchronous active-low aresetn clears both stage valids and the decode state,
// the next byte starts a new string
module utf8_script_run_segmenter
    import utf8sr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,  // byte_value
    input  logic                s_tlast,  // end_of_string
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // code_point[20:0], char_bytes[23:21]
    output logic [M_USER_W-1:0] m_tuser,  // is_target_script[0], begins_run[1]
    output logic                m_tlast   // string_done
);

    in_item_t s_item;
    in_item_t item;
    logic     item_valid;
    logic     advance;
    logic     res_valid;
    result_t  res;
    result_t  m_res;

    assign s_item.byte_value    = s_tdata;
    assign s_item.end_of_string = s_tlast;

    utf8sr_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    utf8sr_decoder u_dec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res)
    );

    utf8sr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_res     (m_res)
    );

    assign m_tdata = {m_res.char_bytes, m_res.code_point};
    assign m_tuser = {m_res.begins_run, m_res.is_target_script};
    assign m_tlast = m_res.string_done;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_bytes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_res.char_bytes != 3'd0) && (m_res.char_bytes <= LEN_FOUR))
        else $error("char_bytes out of range");

    a_class_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_res.is_target_script |->
            ((m_res.code_point >= DEVA_LO) && (m_res.code_point <= DEVA_HI))
            || (m_res.code_point == CP_ZWJ) || (m_res.code_point == CP_ZWNJ))
        else $error("target class on code point outside target set");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while result side free");

endmodule

[verif/tb.sv]
// testbench for the utf-8 decoder with script run segmentation: directed and random byte strings
`timescale 1ns / 100ps

module tb
    import utf8sr_pkg::*;
();

    localparam int TOTAL_BYTES  = 1750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SHOW_LIMIT   = 10;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic [BYTE_W-1:0] b;
        logic              last;
        bit                typed;
        result_t           want;
    } byte_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;
    logic                m_tlast;

    // decoder state kept by the testbench
    logic [REM_W-1:0]    cont_left;
    logic [NBYTES_W-1:0] char_len;
    logic [CP_W-1:0]     cp_accum;
    logic                last_class;
    logic                fresh_string;

    result_t             pending_chars[$];
    logic [BYTE_W-1:0]   str_bytes[$];
    result_t             seen_char;
    result_t             due_char;
    int                  mismatches  = 0;
    int                  items_sent  = 0;
    int                  cycle_count = 0;
    int                  send_idle;
    int                  rcv_idle;

    byte_row_t directed_rows [26] = '{
        '{8'h00, 1'b0, 1'b1, '{21'h000000, LEN_ONE,  1'b0, 1'b1, 1'b0}},
        '{8'h7F, 1'b0, 1'b1, '{21'h00007F, LEN_ONE,  1'b0, 1'b0, 1'b0}},
        '{8'h80, 1'b0, 1'b1, '{21'h000000, LEN_ONE,  1'b0, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, '{21'h000000, LEN_ONE,  1'b0, 1'b0, 1'b0}},
        '{8'hE0, 1'b0, 1'b0, '0},
        '{8'hA4, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'hE2, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h8C, 1'b0, 1'b0, '0},
        '{8'hC3, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b0, '0},
        '{8'hF8, 1'b0, 1'b1, '{21'h000000, LEN_ONE,  1'b0, 1'b0, 1'b0}},
        '{8'hE0, 1'b0, 1'b0, '0},
        '{8'hA5, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hF7, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b1, 1'b1, '{21'h1FFFFF, LEN_FOUR, 1'b0, 1'b1, 1'b1}},
        '{8'hF0, 1'b1, 1'b1, '{21'h000000, LEN_ONE,  1'b0, 1'b1, 1'b1}},
        '{8'hE0, 1'b0, 1'b0, '0},
        '{8'hA4, 1'b1, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b0, '0},
        '{8'h90, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0}
    };

    utf8_script_run_segmenter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // decodes one accepted byte, fin tells whether a character was finished
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last,
                               output bit fin, output result_t r);
        logic [CP_W-1:0]     cp;
        logic [NBYTES_W-1:0] nb;
        logic                cls;
        fin = 1'b0;
        r   = '0;
        cp  = '0;
        nb  = '0;
        if (cont_left == REM_NONE) begin
            if (!b[7]) begin
                cp  = CP_W'(b);
                nb  = LEN_ONE;
                fin = 1'b1;
            end else if ((b & MASK_LEAD2) == PFX_LEAD2) begin
                cp_accum  = {10'd0, b[4:0], 6'd0};
                cont_left = REM_ONE;
                char_len  = LEN_TWO;
            end else if ((b & MASK_LEAD3) == PFX_LEAD3) begin
                cp_accum  = {5'd0, b[3:0], 12'd0};
                cont_left = REM_TWO;
                char_len  = LEN_THREE;
            end else if ((b & MASK_LEAD4) == PFX_LEAD4) begin
                cp_accum  = {b[2:0], 18'd0};
                cont_left = REM_THREE;
                char_len  = LEN_FOUR;
            end else begin
                nb  = LEN_ONE;
                fin = 1'b1;
            end
        end else begin
            cp_accum  = cp_accum | (CP_W'(b[5:0]) << (6 * (int'(cont_left) - 1)));
            cont_left = cont_left - REM_ONE;
            if (cont_left == REM_NONE) begin
                cp  = cp_accum;
                nb  = char_len;
                fin = 1'b1;
            end
        end
        // string ends inside a character, missing bits stay zero
        if (!fin && last) begin
            cp  = cp_accum;
            nb  = char_len - NBYTES_W'(cont_left);
            fin = 1'b1;
        end
        if (fin) begin
            cont_left = REM_NONE;
            char_len  = '0;
            cp_accum  = '0;
            cls = ((cp >= DEVA_LO) && (cp <= DEVA_HI)) || (cp == CP_ZWJ) || (cp == CP_ZWNJ);
            r.code_point       = cp;
            r.char_bytes       = nb;
            r.is_target_script = cls;
            r.begins_run       = fresh_string || (cls != last_class);
            r.string_done      = last;
            last_class   = cls;
            fresh_string = last;
        end
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last,
                             input bit typed, input result_t want);
        bit      fin;
        result_t pred;
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, last, fin, pred);
        if (fin)
            pending_chars.insert(pending_chars.size(), typed ? want : pred);
        items_sent++;
        @(negedge aclk);
    endtask

    function automatic logic [BYTE_W-1:0] cont_byte();
        if ($urandom_range(0, 19) == 0)
            return BYTE_W'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic add_byte(input logic [BYTE_W-1:0] v);
        str_bytes.insert(str_bytes.size(), v);
    endtask

    task automatic push_three(input logic [15:0] cp);
        add_byte({4'hE, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
    endtask

    // mostly well-formed characters, many in or near the script range, some noise and cut-offs
    task automatic build_string();
        int nchars;
        int kind;
        str_bytes.delete();
        nchars = $urandom_range(1, 12);
        repeat (nchars) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
                add_byte(BYTE_W'($urandom_range(0, 127)));
            end else if (kind < 50) begin
                push_three(16'h0900 + 16'($urandom_range(0, 127)));
            end else if (kind < 56) begin
                case ($urandom_range(0, 5))
                    0: push_three(CP_ZWJ[15:0]);
                    1: push_three(CP_ZWNJ[15:0]);
                    2: push_three(16'h200B);
                    3: push_three(16'h200E);
                    4: push_three(16'h08FF);
                    default: push_three(16'h0980);
                endcase
            end else if (kind < 66) begin
                add_byte({3'b110, 5'($urandom_range(0, 31))});
                add_byte(cont_byte());
            end else if (kind < 76) begin
                add_byte({4'b1110, 4'($urandom_range(0, 15))});
                repeat (2) add_byte(cont_byte());
            end else if (kind < 84) begin
                add_byte({5'b11110, 3'($urandom_range(0, 7))});
                repeat (3) add_byte(cont_byte());
            end else begin
                repeat ($urandom_range(1, 3))
                    add_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 2))
                if (str_bytes.size() > 1)
                    void'(str_bytes.pop_back());
        end
    endtask

    always @(negedge aclk) begin
        m_tready <= (rcv_idle == 0) || ($urandom_range(0, 99) >= rcv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_char.code_point       = m_tdata[CP_W-1:0];
            seen_char.char_bytes       = m_tdata[CP_W+NBYTES_W-1:CP_W];
            seen_char.is_target_script = m_tuser[0];
            seen_char.begins_run       = m_tuser[1];
            seen_char.string_done      = m_tlast;
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected transaction: cp=%h bytes=%0d tgt=%b run=%b done=%b",
                             seen_char.code_point, seen_char.char_bytes,
                             seen_char.is_target_script, seen_char.begins_run,
                             seen_char.string_done);
            end else begin
                due_char = pending_chars.pop_front();
                if (seen_char.code_point !== due_char.code_point
                        || seen_char.char_bytes !== due_char.char_bytes
                        || seen_char.is_target_script !== due_char.is_target_script
                        || seen_char.begins_run !== due_char.begins_run
                        || seen_char.string_done !== due_char.string_done) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"mismatch: expected cp=%h bytes=%0d tgt=%b run=%b done=%b,",
                                  " got cp=%h bytes=%0d tgt=%b run=%b done=%b"},
                                 due_char.code_point, due_char.char_bytes,
                                 due_char.is_target_script, due_char.begins_run,
                                 due_char.string_done, seen_char.code_point,
                                 seen_char.char_bytes, seen_char.is_target_script,
                                 seen_char.begins_run, seen_char.string_done);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        aresetn      = 1'b0;
        cont_left    = REM_NONE;
        char_len     = '0;
        cp_accum     = '0;
        last_class   = 1'b0;
        fresh_string = 1'b1;
        send_idle    = 37;
        rcv_idle     = 46;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed_rows[i])
            send_byte(directed_rows[i].b, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].want);
        while (items_sent < TOTAL_BYTES) begin
            if (items_sent >= 2 * TOTAL_BYTES / 3) begin
                send_idle = 0;
                rcv_idle  = 0;
            end else if (items_sent >= TOTAL_BYTES / 3) begin
                send_idle = 46;
                rcv_idle  = 37;
            end
            build_string();
            foreach (str_bytes[k])
                send_byte(str_bytes[k], k == str_bytes.size() - 1, 1'b0, '0);
        end
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
